FILE: hw/rtl/irctok_pkg.sv
// Shared types and constants for the IRC message line tokenizer.
// No dependencies; imported by irctok_parser and irc_message_line_tokenizer_core.
`timescale 1ns / 1ps

package irctok_pkg;

    // Default cap on parameters per line, and the largest value the count can hold.
    localparam int unsigned MAX_PARAMS_DEF = 15;
    localparam int unsigned COUNT_W        = 4;
    localparam int unsigned COUNT_MAX      = (1 << COUNT_W) - 1;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Character classes reported on the output.
    localparam logic [2:0] CLS_DROP     = 3'd0;
    localparam logic [2:0] CLS_COMMAND  = 3'd1;
    localparam logic [2:0] CLS_MIDDLE   = 3'd2;
    localparam logic [2:0] CLS_MARKER   = 3'd3;
    localparam logic [2:0] CLS_TRAILING = 3'd4;
    localparam logic [2:0] CLS_LINE_END = 3'd5;

    typedef struct packed {
        logic [7:0]         char_out;
        logic [2:0]         char_class;
        logic               token_start;
        logic [COUNT_W-1:0] param_index;
        logic [COUNT_W-1:0] param_count;
        logic               param_overflow;
    } t_result;

endpackage

FILE: hw/rtl/irctok_parser.sv
// Parser state machine: classifies one character and updates the line state.
// Depends on irctok_pkg.
`timescale 1ns / 1ps

module irctok_parser #(
    parameter int unsigned MAX_PARAMS = irctok_pkg::MAX_PARAMS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_char,
    input  logic                i_line_end,
    output irctok_pkg::t_result o_result
);
    import irctok_pkg::*;

    localparam logic [COUNT_W-1:0] PCAP =
        COUNT_W'((MAX_PARAMS < COUNT_MAX) ? MAX_PARAMS : COUNT_MAX);

    typedef enum logic [6:0] {
        PH_LINE_START = 7'b0000001,
        PH_PREFIX     = 7'b0000010,
        PH_PRE_CMD    = 7'b0000100,
        PH_CMD        = 7'b0001000,
        PH_BETWEEN    = 7'b0010000,
        PH_MIDDLE     = 7'b0100000,
        PH_TRAILING   = 7'b1000000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_begun, n_begun;
    logic               r_ovf, n_ovf;

    logic               is_space, is_colon;
    logic               want_cmd, want_param;
    logic [COUNT_W-1:0] cur_idx, new_idx;
    logic [7:0]         up_char;

    assign is_space = (i_char == CH_SPACE);
    assign is_colon = (i_char == CH_COLON);
    assign up_char  = (i_char >= 8'h61 && i_char <= 8'h7A) ? (i_char - 8'd32) : i_char;

    // Index of the parameter still open, and of one about to be opened.
    assign cur_idx = r_ovf ? PCAP : ((r_begun != '0) ? (r_begun - 1'b1) : '0);
    assign new_idx = (r_begun < PCAP) ? r_begun : PCAP;

    always_comb begin
        n_phase    = r_phase;
        n_begun    = r_begun;
        n_ovf      = r_ovf;
        want_cmd   = 1'b0;
        want_param = 1'b0;
        o_result                = '0;
        o_result.char_out       = i_char;
        o_result.char_class     = CLS_DROP;

        if (i_line_end) begin
            o_result.char_out   = '0;
            o_result.char_class = CLS_LINE_END;
            n_phase             = PH_LINE_START;
            n_begun             = '0;
            n_ovf               = 1'b0;
        end else begin
            case (r_phase)
                PH_LINE_START: begin
                    if (is_colon) begin
                        n_phase = PH_PREFIX;
                    end else begin
                        want_cmd = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    if (is_space) begin
                        n_phase = PH_PRE_CMD;
                    end
                end
                PH_PRE_CMD: begin
                    want_cmd = 1'b1;
                end
                PH_CMD: begin
                    if (is_space) begin
                        n_phase = PH_BETWEEN;
                    end else begin
                        o_result.char_out   = up_char;
                        o_result.char_class = CLS_COMMAND;
                    end
                end
                PH_BETWEEN: begin
                    if (is_colon) begin
                        want_param          = 1'b1;
                        o_result.char_class = CLS_MARKER;
                        n_phase             = PH_TRAILING;
                    end else if (!is_space) begin
                        want_param          = 1'b1;
                        o_result.char_class = CLS_MIDDLE;
                        n_phase             = PH_MIDDLE;
                    end
                end
                PH_MIDDLE: begin
                    if (is_space) begin
                        n_phase = PH_BETWEEN;
                    end else begin
                        o_result.char_class  = CLS_MIDDLE;
                        o_result.param_index = cur_idx;
                    end
                end
                PH_TRAILING: begin
                    o_result.char_class  = CLS_TRAILING;
                    o_result.param_index = cur_idx;
                end
                default: begin
                    want_cmd = 1'b1;
                end
            endcase

            // Waiting for the command: spaces are skipped, the first other
            // character opens it.
            if (want_cmd) begin
                n_phase = PH_PRE_CMD;
                if (!is_space) begin
                    o_result.char_out    = up_char;
                    o_result.char_class  = CLS_COMMAND;
                    o_result.token_start = 1'b1;
                    n_phase              = PH_CMD;
                end
            end

            if (want_param) begin
                o_result.token_start = 1'b1;
                o_result.param_index = new_idx;
                if (r_begun < PCAP) begin
                    n_begun = r_begun + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end

        o_result.param_count    = i_line_end ? r_begun : n_begun;
        o_result.param_overflow = i_line_end ? r_ovf : n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE_START;
            r_begun <= '0;
            r_ovf   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_begun <= n_begun;
            r_ovf   <= n_ovf;
        end
    end

endmodule

FILE: hw/rtl/irc_message_line_tokenizer_core.sv
// IRC message line tokenizer, top level. Depends on irctok_pkg and irctok_parser.
// Characters of one message line enter one word per cycle while o_stall is low;
// each word yields exactly one result word that tags the character as dropped,
// command, middle parameter, trailing marker or trailing text, or reports the
// end of the line. A word passes an input register, the parser logic and an
// output register; the parser result loads into the output register once the
// input register holds the word and the output register can take it. With the
// output not stalled the block takes and returns one word every cycle. The
// throughput is set by the parser state update, which every word goes through.
// A leading ':' opens a source prefix that is dropped through the first space,
// command letters are upper-cased, and a parameter beginning with ':' takes the
// rest of the line. The parameter count saturates at the smaller of MAX_PARAMS
// and 15; a parameter begun while the count sits there takes the cap as its
// index and raises param_overflow for the rest of the line.
`timescale 1ns / 1ps

module irc_message_line_tokenizer_core #(
    parameter int unsigned MAX_PARAMS = irctok_pkg::MAX_PARAMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel.
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_char_in,
    input  logic                              i_line_end,
    // Result channel.
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [7:0]                        o_char_out,
    output logic [2:0]                        o_char_class,
    output logic                              o_token_start,
    output logic [irctok_pkg::COUNT_W-1:0]    o_param_index,
    output logic [irctok_pkg::COUNT_W-1:0]    o_param_count,
    output logic                              o_param_overflow
);
    import irctok_pkg::*;

    localparam logic [COUNT_W-1:0] PCAP =
        COUNT_W'((MAX_PARAMS < COUNT_MAX) ? MAX_PARAMS : COUNT_MAX);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;

    // Output register.
    logic       r_out_valid;
    t_result    r_out;

    t_result    parse_res;
    logic       out_ready;
    logic       fire;

    // The output register can take a new word when it is empty or draining.
    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_char <= i_char_in;
            r_in_end  <= i_line_end;
        end
    end

    irctok_parser #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_char     (r_in_char),
        .i_line_end (r_in_end),
        .o_result   (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= parse_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_char_out       = r_out.char_out;
    assign o_char_class     = r_out.char_class;
    assign o_token_start    = r_out.token_start;
    assign o_param_index    = r_out.param_index;
    assign o_param_count    = r_out.param_count;
    assign o_param_overflow = r_out.param_overflow;

`ifndef NO_ASSERTIONS
    // The overflow flag is only raised once the count has reached its cap.
    a_ovf_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_param_overflow) |-> (o_param_count == PCAP))
        else $error("overflow flagged below the parameter cap");

    // No parameter index goes beyond the cap.
    a_index_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_param_index <= PCAP))
        else $error("parameter index beyond the cap");

    // Token starts only mark the command, a middle parameter or the marker.
    a_start_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_start) |->
            (o_char_class == CLS_COMMAND || o_char_class == CLS_MIDDLE ||
             o_char_class == CLS_MARKER))
        else $error("token start on a character outside any token");

    // A parameter character can only be reported once a parameter was begun.
    a_param_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_char_class == CLS_MIDDLE || o_char_class == CLS_MARKER ||
                     o_char_class == CLS_TRAILING)) |-> (o_param_count != '0))
        else $error("parameter character with zero parameters counted");
`endif

endmodule
